>>> rtl/frd_pkg.sv
// Shared types and constants for the fractional divider rate solver.
package frd_pkg;

    localparam int RATE_W   = 32;
    localparam int DIV_W    = 9;
    localparam int FRAC_W   = 14;
    localparam int REM_W    = 64;
    localparam int DEN_W    = DIV_W + FRAC_W;
    localparam int FRAC_DEN = 16384;
    localparam int DIV_MIN  = 4;
    localparam int DIV_MAX  = 511;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_LOW  = 2'd1,
        ST_REQ_ZERO = 2'd2
    } frd_status_t;

    typedef enum logic {
        OP_SOLVE = 1'b0,
        OP_RATE  = 1'b1
    } frd_op_t;

    typedef enum logic {
        CFG_SOURCE_RATE   = 1'b0,
        CFG_ROUND_CLOSEST = 1'b1
    } frd_cfg_idx_t;

    typedef struct packed {
        frd_op_t           op;
        logic [DIV_W-1:0]  divider;
        logic [FRAC_W-1:0] fraction;
        logic [RATE_W-1:0] q1;
        frd_status_t       status;
    } frd_item_t;

    typedef struct packed {
        logic              valid;
        logic [REM_W-1:0]  rem;
        logic [RATE_W-1:0] den;
        logic [RATE_W-1:0] quo;
        frd_item_t         item;
    } frd_lane_t;

endpackage

>>> rtl/frd_div_cell.sv
// One restoring-division cell: one quotient bit per cell, registered.
module frd_div_cell #(
    parameter int K = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  frd_pkg::frd_lane_t lane_in,
    output frd_pkg::frd_lane_t lane_out
);
    import frd_pkg::*;

    frd_lane_t        lane_reg;
    frd_lane_t        lane_next;
    logic [REM_W-1:0] shifted;
    logic             ge;

    always_comb
    begin
        shifted   = {{(REM_W-RATE_W){1'b0}}, lane_in.den} << K;
        ge        = (lane_in.rem >= shifted);
        lane_next = lane_in;
        if (ge)
        begin
            lane_next.rem = lane_in.rem - shifted;
        end
        lane_next.quo = {lane_in.quo[RATE_W-2:0], ge};
    end

    // Only the valid bit is cleared by reset; the payload just follows it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg.valid <= 1'b0;
        end
        else if (advance)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

>>> rtl/frd_mid_cell.sv
// Stage between the quotient and fraction divisions: scale remainder, add rounding.
module frd_mid_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       round_closest,
    input  frd_pkg::frd_lane_t         lane_in,
    output frd_pkg::frd_lane_t         lane_out
);
    import frd_pkg::*;

    frd_lane_t         lane_reg;
    frd_lane_t         lane_next;
    logic [RATE_W-1:0] adj;

    always_comb
    begin
        adj = round_closest ? (lane_in.den >> 1) : (lane_in.den - RATE_W'(1));
        lane_next         = lane_in;
        lane_next.item.q1 = lane_in.quo;
        lane_next.rem     = ({{(REM_W-RATE_W){1'b0}}, lane_in.rem[RATE_W-1:0]} << FRAC_W)
                          + {{(REM_W-RATE_W){1'b0}}, adj};
        lane_next.quo     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg.valid <= 1'b0;
        end
        else if (advance)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

>>> rtl/frd_sel_cell.sv
// Stage that carries, clamps and picks settings, then sets up the rate division.
module frd_sel_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic [frd_pkg::RATE_W-1:0] source_rate,
    input  frd_pkg::frd_lane_t         lane_in,
    output frd_pkg::frd_lane_t         lane_out
);
    import frd_pkg::*;

    frd_lane_t         lane_reg;
    frd_lane_t         lane_next;
    logic [RATE_W:0]   q;
    logic [FRAC_W:0]   f;
    logic [DIV_W-1:0]  div_sel;
    logic [FRAC_W-1:0] frac_sel;
    logic [DEN_W-1:0]  den3;

    always_comb
    begin
        f = lane_in.quo[FRAC_W:0];
        q = {1'b0, lane_in.item.q1};
        if (f == (FRAC_W+1)'(FRAC_DEN))
        begin
            f = '0;
            q = q + (RATE_W+1)'(1);
        end
        if (lane_in.item.op == OP_RATE)
        begin
            div_sel  = lane_in.item.divider;
            frac_sel = lane_in.item.fraction;
        end
        else if (lane_in.item.status == ST_REQ_ZERO)
        begin
            div_sel  = '0;
            frac_sel = '0;
        end
        else if (q < (RATE_W+1)'(DIV_MIN))
        begin
            div_sel  = DIV_W'(DIV_MIN);
            frac_sel = '0;
        end
        else if (q > (RATE_W+1)'(DIV_MAX))
        begin
            div_sel  = DIV_W'(DIV_MAX);
            frac_sel = FRAC_W'(FRAC_DEN - 1);
        end
        else
        begin
            div_sel  = q[DIV_W-1:0];
            frac_sel = f[FRAC_W-1:0];
        end
        den3 = {div_sel, {FRAC_W{1'b0}}} + {{DIV_W{1'b0}}, frac_sel};

        lane_next               = lane_in;
        lane_next.item.divider  = div_sel;
        lane_next.item.fraction = frac_sel;
        lane_next.den           = {{(RATE_W-DEN_W){1'b0}}, den3};
        lane_next.rem           = ({{(REM_W-RATE_W){1'b0}}, source_rate} << FRAC_W)
                                + {{(REM_W-DEN_W){1'b0}}, den3} - REM_W'(1);
        lane_next.quo           = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg.valid <= 1'b0;
        end
        else if (advance)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

>>> rtl/fractional_divider_rate_solver.sv
// Top level of the fractional divider rate solver: a chain of division cells.
// The chain from accepted transaction to result holds 32 quotient cells,
// one scaling stage, 15 fraction cells, one select stage and 32 rate cells.
// Throughput: one transaction per cycle unless stalled; one quotient bit per cell.
// Reset clears the valid bits of every cell and both configuration registers.
module fractional_divider_rate_solver (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [frd_pkg::RATE_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        opcode,
    input  logic [frd_pkg::RATE_W-1:0]  desired_rate,
    input  logic [frd_pkg::DIV_W-1:0]   divider_in,
    input  logic [frd_pkg::FRAC_W-1:0]  fraction_in,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [frd_pkg::DIV_W-1:0]   divider_out,
    output logic [frd_pkg::FRAC_W-1:0]  fraction_out,
    output logic [frd_pkg::RATE_W-1:0]  achieved_rate,
    output logic [1:0]                  status
);
    import frd_pkg::*;

    logic [RATE_W-1:0] source_rate_reg;
    logic              round_closest_reg;
    logic              advance;
    frd_lane_t         entry;
    frd_lane_t         d1 [0:RATE_W];
    frd_lane_t         d2 [0:FRAC_W+1];
    frd_lane_t         d3 [0:RATE_W];
    frd_lane_t         last;

    // Configuration is always taken; the user must change it only while the chain is idle, unchecked by the block.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_rate_reg   <= '0;
            round_closest_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (frd_cfg_idx_t'(cfg_index))
                CFG_SOURCE_RATE:   source_rate_reg   <= cfg_data;
                CFG_ROUND_CLOSEST: round_closest_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // The whole chain moves together; hold everything while a valid output is stalled.
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    // Entry: classify the transaction and load the first division (parent / request).
    always_comb
    begin
        entry.valid         = in_valid;
        entry.rem           = {{(REM_W-RATE_W){1'b0}}, source_rate_reg};
        entry.den           = desired_rate;
        entry.quo           = '0;
        entry.item.op       = frd_op_t'(opcode);
        entry.item.divider  = divider_in;
        entry.item.fraction = fraction_in;
        entry.item.q1       = '0;
        if (opcode == OP_RATE)
        begin
            entry.item.status = (divider_in < DIV_W'(DIV_MIN)) ? ST_DIV_LOW : ST_OK;
        end
        else
        begin
            entry.item.status = (desired_rate == '0) ? ST_REQ_ZERO : ST_OK;
        end
    end

    assign d1[0] = entry;

    genvar i;
    generate
        for (i = 0; i < RATE_W; i++)
        begin : g_quo
            frd_div_cell #(.K(RATE_W - 1 - i)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .lane_in  (d1[i]),
                .lane_out (d1[i+1])
            );
        end
    endgenerate

    // Scale the remainder to fraction units and add the rounding offset.
    frd_mid_cell u_mid (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .round_closest (round_closest_reg),
        .lane_in       (d1[RATE_W]),
        .lane_out      (d2[0])
    );

    // Fraction quotient never exceeds the denominator, so 15 bits suffice.
    generate
        for (i = 0; i <= FRAC_W; i++)
        begin : g_frac
            frd_div_cell #(.K(FRAC_W - i)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .lane_in  (d2[i]),
                .lane_out (d2[i+1])
            );
        end
    endgenerate

    // Carry the fraction, clamp the divider and set up the rate division.
    frd_sel_cell u_sel (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .source_rate (source_rate_reg),
        .lane_in     (d2[FRAC_W+1]),
        .lane_out    (d3[0])
    );

    // Rounded-up rate: the numerator already carries the divisor minus one.
    generate
        for (i = 0; i < RATE_W; i++)
        begin : g_rate
            frd_div_cell #(.K(RATE_W - 1 - i)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .lane_in  (d3[i]),
                .lane_out (d3[i+1])
            );
        end
    endgenerate

    // The last rate cell is the output register.
    assign last          = d3[RATE_W];
    assign out_valid     = last.valid;
    assign divider_out   = last.item.divider;
    assign fraction_out  = last.item.fraction;
    assign achieved_rate = (last.item.status == ST_OK) ? last.quo : '0;
    assign status        = last.item.status;

    a_zero_req: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_REQ_ZERO |-> divider_out == '0 && fraction_out == '0)
        else $error("zero request left nonzero settings");

    a_solve_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK && last.item.op == OP_SOLVE
        |-> divider_out >= DIV_W'(DIV_MIN))
        else $error("solved divider below minimum");

    a_mid_flow: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> d2[0].valid == $past(d1[RATE_W].valid))
        else $error("transaction lost between quotient and fraction cells");

endmodule

>>> tb/testbench.sv
// Self-checking bench for the fractional divider rate solver.
module testbench;
    import frd_pkg::*;

    typedef struct packed {
        frd_op_t           op;
        logic [RATE_W-1:0] req;
        logic [DIV_W-1:0]  divider;
        logic [FRAC_W-1:0] fraction;
    } rate_request_t;

    typedef struct packed {
        logic [DIV_W-1:0]  divider;
        logic [FRAC_W-1:0] fraction;
        logic [RATE_W-1:0] rate;
        logic [1:0]        status;
    } divider_setting_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic [RATE_W-1:0]   cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic                opcode;
    logic [RATE_W-1:0]   desired_rate;
    logic [DIV_W-1:0]    divider_in;
    logic [FRAC_W-1:0]   fraction_in;
    logic                out_valid;
    logic                out_stall;
    logic [DIV_W-1:0]    divider_out;
    logic [FRAC_W-1:0]   fraction_out;
    logic [RATE_W-1:0]   achieved_rate;
    logic [1:0]          status;

    // Predictor copy of the configuration registers.
    logic [RATE_W-1:0]   parent_hz;
    logic                nearest_mode;

    rate_request_t       pending_requests[$];
    divider_setting_t    expected_settings[$];
    int                  mismatch_count;
    int                  burst_left;
    int                  gap_left;
    int                  stall_phase;
    logic                hold_sender;

    fractional_divider_rate_solver dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .desired_rate   (desired_rate),
        .divider_in     (divider_in),
        .fraction_in    (fraction_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .divider_out    (divider_out),
        .fraction_out   (fraction_out),
        .achieved_rate  (achieved_rate),
        .status         (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Output rate for a divider setting, rounded up: parent * 16384 / (16384 * div + frac).
    function automatic logic [RATE_W-1:0] divided_rate(logic [63:0] div, logic [63:0] frac);
        logic [63:0] den;
        logic [63:0] num;
        begin
            den = 64'(FRAC_DEN) * div + frac;
            num = 64'(parent_hz) * 64'(FRAC_DEN);
            return RATE_W'((num + den - 64'd1) / den);
        end
    endfunction

    function automatic divider_setting_t solve_settings(rate_request_t r);
        divider_setting_t s;
        logic [63:0] quo;
        logic [63:0] scaled;
        logic [63:0] frac;
        logic [63:0] req;
        begin
            s = '0;
            req = 64'(r.req);
            if (r.op == OP_RATE)
            begin
                s.divider = r.divider;
                s.fraction = r.fraction;
                if (r.divider < DIV_W'(DIV_MIN))
                    s.status = ST_DIV_LOW;
                else
                    s.rate = divided_rate(64'(r.divider), 64'(r.fraction));
            end
            else if (req == 64'd0)
            begin
                s.status = ST_REQ_ZERO;
            end
            else
            begin
                quo = 64'(parent_hz) / req;
                scaled = (64'(parent_hz) % req) * 64'(FRAC_DEN);
                if (nearest_mode)
                    frac = (scaled + req / 64'd2) / req;
                else
                    frac = (scaled + req - 64'd1) / req;
                // A fraction that rounds to a whole step carries into the divider.
                if (frac == 64'(FRAC_DEN))
                begin
                    frac = 64'd0;
                    quo = quo + 64'd1;
                end
                if (quo < 64'(DIV_MIN))
                begin
                    quo = 64'(DIV_MIN);
                    frac = 64'd0;
                end
                else if (quo > 64'(DIV_MAX))
                begin
                    quo = 64'(DIV_MAX);
                    frac = 64'(FRAC_DEN - 1);
                end
                s.divider = DIV_W'(quo);
                s.fraction = FRAC_W'(frac);
                s.rate = divided_rate(quo, frac);
                s.status = ST_OK;
            end
            return s;
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        begin
            $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
            mismatch_count++;
        end
    endtask

    // Driver: bursts of transactions with random gaps; hold payload while stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode <= OP_SOLVE;
            desired_rate <= '0;
            divider_in <= '0;
            fraction_in <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_settings.push_back(solve_settings(pending_requests.pop_front()));
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (hold_sender || pending_requests.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    opcode <= pending_requests[0].op;
                    desired_rate <= pending_requests[0].req;
                    divider_in <= pending_requests[0].divider;
                    fraction_in <= pending_requests[0].fraction;
                    if (burst_left > 0)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(40);
                        gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
                    end
                end
            end
        end
    end

    // Monitor: compare each accepted result against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        divider_setting_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_settings.size() == 0)
                begin
                    report_mismatch("unexpected result, divider", 64'(divider_out), 64'd0);
                end
                else
                begin
                    want = expected_settings.pop_front();
                    if (divider_out !== want.divider)
                        report_mismatch("divider_out", 64'(divider_out), 64'(want.divider));
                    if (fraction_out !== want.fraction)
                        report_mismatch("fraction_out", 64'(fraction_out), 64'(want.fraction));
                    if (achieved_rate !== want.rate)
                        report_mismatch("achieved_rate", 64'(achieved_rate), 64'(want.rate));
                    if (status !== want.status)
                        report_mismatch("status", 64'(status), 64'(want.status));
                end
            end
            // Stall pattern: quiet windows alternate with random and periodic stalls.
            stall_phase <= (stall_phase + 1) % 300;
            if (stall_phase < 100)
                out_stall <= 1'b0;
            else if (stall_phase < 200)
                out_stall <= ($urandom_range(2) == 0);
            else
                out_stall <= (stall_phase % 5) < 2;
        end
    end

    task automatic write_register(frd_cfg_idx_t idx, logic [RATE_W-1:0] value);
        begin
            @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= value;
            do @(posedge clk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            if (idx == CFG_SOURCE_RATE)
                parent_hz = value;
            else
                nearest_mode = value[0];
        end
    endtask

    task automatic queue_request(frd_op_t op, logic [RATE_W-1:0] req,
                                 logic [DIV_W-1:0] div, logic [FRAC_W-1:0] frac);
        rate_request_t r;
        begin
            r.op = op;
            r.req = req;
            r.divider = div;
            r.fraction = frac;
            pending_requests.push_back(r);
        end
    endtask

    // Wait until every queued request has been sent and answered, then drain the pipe.
    task automatic wait_idle();
        begin
            while (pending_requests.size() != 0 || in_valid || expected_settings.size() != 0)
                @(posedge clk);
            repeat (100) @(posedge clk);
        end
    endtask

    // Requests near parent / divider for the clamp range, plus full-range noise.
    task automatic queue_random(int count);
        logic [63:0] div;
        logic [63:0] target;
        begin
            for (int k = 0; k < count; k++)
            begin
                case ($urandom_range(5))
                    0: queue_request(OP_RATE, $urandom, DIV_W'($urandom), FRAC_W'($urandom));
                    1: queue_request(OP_RATE, $urandom, DIV_W'($urandom_range(8)),
                                     FRAC_W'($urandom));
                    2: queue_request(OP_SOLVE, $urandom, DIV_W'($urandom), FRAC_W'($urandom));
                    3: queue_request(OP_SOLVE, $urandom_range(3), DIV_W'($urandom),
                                     FRAC_W'($urandom));
                    default:
                    begin
                        div = 64'($urandom_range(600, 2));
                        target = 64'(parent_hz) / div + 64'($urandom_range(64)) - 64'd32;
                        queue_request(OP_SOLVE, RATE_W'(target), DIV_W'($urandom),
                                      FRAC_W'($urandom));
                    end
                endcase
            end
        end
    endtask

    initial
    begin
        logic [RATE_W-1:0] parents[5];
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SOURCE_RATE;
        cfg_data = '0;
        hold_sender = 1'b0;
        mismatch_count = 0;
        parent_hz = '0;
        nearest_mode = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero parent from reset, then extremes, carry and clamps.
        queue_request(OP_SOLVE, 32'd1000, '0, '0);
        queue_request(OP_RATE, '0, 9'd100, 14'd5);
        wait_idle();
        write_register(CFG_SOURCE_RATE, 32'd24000000);
        write_register(CFG_ROUND_CLOSEST, 32'd1);
        queue_request(OP_SOLVE, 32'd0, '1, '1);
        queue_request(OP_SOLVE, 32'hFFFFFFFF, '0, '0);
        queue_request(OP_SOLVE, 32'd1, '0, '0);
        queue_request(OP_SOLVE, 32'd46966, '0, '0);
        queue_request(OP_SOLVE, 32'd6000000, '0, '0);
        queue_request(OP_SOLVE, 32'd1000000, '0, '0);
        queue_request(OP_SOLVE, 32'd2399999, '0, '0);
        queue_request(OP_SOLVE, 32'd7000001, '0, '0);
        queue_request(OP_RATE, '1, 9'd3, 14'd16383);
        queue_request(OP_RATE, '0, 9'd0, 14'd0);
        queue_request(OP_RATE, '0, 9'd4, 14'd0);
        queue_request(OP_RATE, '0, 9'd511, 14'd16383);
        queue_request(OP_RATE, '0, 9'd255, 14'd8192);
        wait_idle();
        write_register(CFG_SOURCE_RATE, 32'hFFFFFFFF);
        write_register(CFG_ROUND_CLOSEST, 32'd0);
        queue_request(OP_SOLVE, 32'd858993459, '0, '0);
        queue_request(OP_SOLVE, 32'd3, '0, '0);
        queue_request(OP_RATE, '0, 9'd4, 14'd0);
        queue_request(OP_RATE, '0, 9'd511, 14'd16383);

        parents[0] = 32'd1;
        parents[1] = 32'd100000000;
        parents[2] = 32'hFFFFFFFF;
        parents[3] = 32'd0;
        parents[4] = 32'd24000000;
        for (int p = 0; p < 10; p++)
        begin
            wait_idle();
            write_register(CFG_SOURCE_RATE, (p < 5) ? parents[p] : $urandom);
            write_register(CFG_ROUND_CLOSEST, RATE_W'(p % 2));
            queue_random(55);
            // Pause the sender once until the pipe is empty, then resume.
            if (p == 6)
            begin
                while (pending_requests.size() > 25) @(posedge clk);
                hold_sender = 1'b1;
                while (in_valid || expected_settings.size() != 0) @(posedge clk);
                hold_sender = 1'b0;
            end
        end
        wait_idle();
        write_register(CFG_SOURCE_RATE, $urandom);
        write_register(CFG_ROUND_CLOSEST, 32'd1);
        queue_random(550);
        wait_idle();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
rtl/frd_pkg.sv
rtl/frd_div_cell.sv
rtl/frd_mid_cell.sv
rtl/frd_sel_cell.sv
rtl/fractional_divider_rate_solver.sv
tb/testbench.sv
